[design/tcw_pkg.sv]
// Shared types and constants for the text console cell writer.
// Holds the beat structs, the mode codes and the controller/datapath links.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [7:0]        BLANK_CHAR   = 8'h20;
  localparam logic [7:0]        NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]        RESET_COLOR  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_COLOR, BLANK_CHAR};

  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_ERASE = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       char_code;
    logic [7:0]       cell_attr;
    logic [COL_W-1:0] pos_column;
    logic [ROW_W-1:0] pos_row;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [COL_W-1:0]  cursor_column;
    logic              did_scroll;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic exec;
    logic fill_step;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_scroll;
    logic fill_done;
  } tcw_sts_t;

endpackage

`default_nettype wire

[design/tcw_ctrl.sv]
// Controller state machine of the text console cell writer.
// Drives the datapath commands and both handshakes; depends on tcw_pkg.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire tcw_sts_t sts,
  output tcw_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_FILL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scroll ? S_FILL : S_DONE;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            state_nxt     = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tcw_datapath.sv]
// Datapath of the text console cell writer: screen memory, cursor, row ring.
// Scrolling rotates the top-row pointer and refills one row; uses tcw_pkg.
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tcw_cmd_t   cmd,
  output tcw_sts_t        sts,
  input  wire in_item_t   in_item,
  input  wire logic [7:0] text_color,
  output out_item_t       out_item
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0]  COL_LIM   = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  ROW_LIM   = ROW_W'(ROWS);
  localparam logic [ROW_W:0]    ROW_WRAP  = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(COLUMNS);

  logic [CELL_W-1:0] mem [CELLS];

  in_item_t          item_r;
  out_item_t         out_r;
  logic [COL_W-1:0]  cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [COL_W-1:0]  fill_cnt_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              scroll_r;
  logic              hit_r;
  logic [CELL_W-1:0] rdata_r;

  logic              in_range;
  logic              ex_we, ex_scroll, ex_hit;
  logic [ROW_W-1:0]  ex_row, row_sel;
  logic [COL_W-1:0]  ex_col, ex_cursor, col_sel;
  logic [CELL_W-1:0] ex_data, mem_wd;
  logic [ROW_W:0]    phys_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] cell_addr, mem_addr;
  logic              mem_we;

  assign in_range = (item_r.pos_column < COL_LIM) && (item_r.pos_row < ROW_LIM);

  always_comb begin
    ex_we     = 1'b0;
    ex_scroll = 1'b0;
    ex_hit    = 1'b0;
    ex_row    = LAST_ROW;
    ex_col    = cursor_r;
    ex_cursor = cursor_r;
    ex_data   = {text_color, item_r.char_code};
    unique case (item_r.mode)
      MODE_PUT: begin
        if (item_r.char_code == NEWLINE_CHAR) begin
          ex_scroll = 1'b1;
          ex_cursor = '0;
        end else begin
          ex_we = 1'b1;
          if (cursor_r == LAST_COL) begin
            ex_scroll = 1'b1;
            ex_cursor = '0;
          end else begin
            ex_cursor = cursor_r + 1'b1;
          end
        end
      end
      MODE_ERASE: begin
        if (cursor_r != '0) begin
          ex_we     = 1'b1;
          ex_col    = cursor_r - 1'b1;
          ex_cursor = cursor_r - 1'b1;
          ex_data   = {text_color, BLANK_CHAR};
        end
      end
      MODE_WRITE: begin
        ex_row  = item_r.pos_row;
        ex_col  = item_r.pos_column;
        ex_data = {item_r.cell_attr, item_r.char_code};
        ex_we   = in_range;
      end
      MODE_READ: begin
        ex_row = item_r.pos_row;
        ex_col = item_r.pos_column;
        ex_hit = in_range;
      end
      default: begin
        ex_we = 1'b0;
      end
    endcase
  end

  // Logical rows are mapped onto a ring of physical rows starting at base_r.
  assign row_sel   = cmd.fill_step ? LAST_ROW : ex_row;
  assign col_sel   = cmd.fill_step ? fill_cnt_r : ex_col;
  assign phys_sum  = {1'b0, row_sel} + {1'b0, base_r};
  assign phys_row  = (phys_sum >= ROW_WRAP) ? ROW_W'(phys_sum - ROW_WRAP)
                                            : ROW_W'(phys_sum);
  assign cell_addr = ADDR_W'(phys_row) * ROW_PITCH + ADDR_W'(col_sel);

  assign mem_addr = cmd.clr_step ? clr_cnt_r : cell_addr;
  assign mem_we   = cmd.clr_step || cmd.fill_step || (cmd.exec && ex_we);

  always_comb begin
    priority if (cmd.clr_step) begin
      mem_wd = RESET_CELL;
    end else if (cmd.fill_step) begin
      mem_wd = {text_color, BLANK_CHAR};
    end else begin
      mem_wd = ex_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (cmd.exec) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_comb begin
    cursor_nxt = cursor_r;
    base_nxt   = base_r;
    if (cmd.exec) begin
      cursor_nxt = ex_cursor;
      if (ex_scroll) begin
        base_nxt = (base_r == LAST_ROW) ? '0 : base_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      base_r     <= '0;
      clr_cnt_r  <= '0;
      fill_cnt_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      base_r   <= base_nxt;
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.exec) begin
        fill_cnt_r <= '0;
      end else if (cmd.fill_step) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      scroll_r <= ex_scroll;
      hit_r    <= ex_hit;
    end
    if (cmd.out_load) begin
      out_r.cell_word     <= hit_r ? rdata_r : '0;
      out_r.cursor_column <= cursor_r;
      out_r.did_scroll    <= scroll_r;
    end
  end

  assign sts.clear_done  = (clr_cnt_r == LAST_ADDR);
  assign sts.fill_done   = (fill_cnt_r == LAST_COL);
  assign sts.need_scroll = ex_scroll;
  assign out_item        = out_r;

endmodule

`default_nettype wire

[design/text_console_cell_writer_top.sv]
// Top level of the text console cell writer: controller, datapath, APB register.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_item (in_item_t)
//   out_     output     out_valid/ready    out_item (out_item_t)
//   APB      input      psel/penable       paddr/pwdata/prdata
//
// Without a scroll an item is executed, then its result is loaded into the output register.
// A scroll adds a fill pass between execute and result load that blanks the new bottom row cell by cell.
// After reset a clearing pass writes every cell, during which no beat is
// accepted; register writes are still taken.
// A new beat is accepted while the previous result waits in the output register.
`default_nettype none

module text_console_cell_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tcw_cmd_t   cmd;
  tcw_sts_t   sts;
  logic [7:0] text_color_r, text_color_nxt;
  logic       reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);

  assign text_color_nxt = reg_wr ? pwdata[7:0] : text_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color_r} : 32'd0;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_item    (in_item),
    .text_color (text_color_r),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

[design/tcw_checker.sv]
// Port-level checker for the text console cell writer, bound to the top level.
// Depends on tcw_pkg and text_console_cell_writer_top.
`default_nettype none

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  localparam logic [COL_W-1:0] COL_LIM = COL_W'(COLUMNS);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result beat changed or dropped.");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.cursor_column < COL_LIM)
    else $error("Cursor column beyond the last column.");

  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.did_scroll |-> out_item.cursor_column == '0)
    else $error("Scroll did not return the cursor to column zero.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second input beat taken while the first is in work.");

endmodule

bind text_console_cell_writer_top tcw_checker #(.COLUMNS(COLUMNS)) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the text console cell writer.
// Streams directed and random beats, predicts every result and programs text_color over APB.
// Depends on tcw_pkg and text_console_cell_writer_top.
`default_nettype none

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = COLUMNS + 20;
  localparam int LIMIT_CYCLES = 600000;

  localparam logic [2:0] TEXT_COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;
  logic [31:0] prdata;
  logic        pready;

  logic [CELL_W-1:0] screen_model [CELLS];
  logic [COL_W-1:0]  cursor_model;
  logic [7:0]        color_model;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int items_queued   = 0;
  int items_accepted = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_wait      = 0;
  bit send_burst     = 1'b0;
  bit recv_burst     = 1'b0;

  text_console_cell_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void scroll_model();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {color_model, BLANK_CHAR};
  endfunction

  function automatic out_item_t console_step(in_item_t item);
    out_item_t res;
    int        bottom;
    int        cell_index;
    res = '0;
    if (int'(cursor_model) >= COLUMNS) cursor_model = '0;
    bottom = (ROWS - 1) * COLUMNS;
    cell_index = int'(item.pos_row) * COLUMNS + int'(item.pos_column);
    case (item.mode)
      MODE_PUT: begin
        if (item.char_code == NEWLINE_CHAR) begin
          scroll_model();
          cursor_model = '0;
          res.did_scroll = 1'b1;
        end else begin
          screen_model[bottom + int'(cursor_model)] = {color_model, item.char_code};
          cursor_model = cursor_model + 1'b1;
          if (int'(cursor_model) >= COLUMNS) begin
            scroll_model();
            cursor_model = '0;
            res.did_scroll = 1'b1;
          end
        end
      end
      MODE_ERASE: begin
        if (cursor_model != '0) begin
          cursor_model = cursor_model - 1'b1;
          screen_model[bottom + int'(cursor_model)] = {color_model, BLANK_CHAR};
        end
      end
      MODE_WRITE: begin
        if (int'(item.pos_column) < COLUMNS && int'(item.pos_row) < ROWS)
          screen_model[cell_index] = {item.cell_attr, item.char_code};
      end
      default: begin
        if (int'(item.pos_column) < COLUMNS && int'(item.pos_row) < ROWS)
          res.cell_word = screen_model[cell_index];
      end
    endcase
    res.cursor_column = cursor_model;
    return res;
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode       = mode_t'($urandom_range(0, 3));
    it.char_code  = 8'($urandom_range(0, 255));
    it.cell_attr  = 8'($urandom_range(0, 255));
    it.pos_column = COL_W'($urandom_range(0, 127));
    it.pos_row    = ROW_W'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic in_item_t make_item(mode_t m, logic [7:0] ch, logic [7:0] attr,
                                         logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_item_t it;
    it.mode       = m;
    it.char_code  = ch;
    it.cell_attr  = attr;
    it.pos_column = col;
    it.pos_row    = row;
    return it;
  endfunction

  function automatic in_item_t place(in_item_t it);
    in_item_t res;
    res = it;
    if ($urandom_range(0, 9) != 0) begin
      res.pos_column = COL_W'($urandom_range(0, COLUMNS - 1));
      res.pos_row    = ROW_W'($urandom_range(0, ROWS - 1));
    end
    return res;
  endfunction

  // Input driver: one beat in flight, a fresh gap drawn after every accepted beat.
  always @(posedge clk) begin
    int gap_now;
    gap_now = send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(console_step(in_item));
        items_accepted++;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap_now = draw_wait(send_burst);
      end
      if (!in_valid || in_ready) begin
        if (gap_now != 0) begin
          in_valid <= 1'b0;
          send_gap <= gap_now - 1;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
          send_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          send_gap <= 0;
        end
      end
    end
  end

  // Result monitor: checks each beat against the oldest prediction, stalls at random.
  always @(posedge clk) begin
    out_item_t want;
    int        wait_now;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (error_count < 10) $display("Unexpected result beat: %p", out_item);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.cell_word !== want.cell_word ||
            out_item.cursor_column !== want.cursor_column ||
            out_item.did_scroll !== want.did_scroll) begin
          if (error_count < 10)
            $display({"Result mismatch: expected cell %h col %0d scroll %b, ",
                      "got cell %h col %0d scroll %b"},
                     want.cell_word, want.cursor_column, want.did_scroll,
                     out_item.cell_word, out_item.cursor_column, out_item.did_scroll);
          error_count++;
        end
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      wait_now = draw_wait(recv_burst);
      if (wait_now == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_wait <= wait_now;
      end
    end else if (!out_ready) begin
      if (recv_wait <= 1) out_ready <= 1'b1;
      else recv_wait <= recv_wait - 1;
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic submit(in_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_until_idle();
    while (items_accepted != items_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_color(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TEXT_COLOR_ADDR) color_model = value[7:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TEXT_COLOR_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== color_model) begin
      if (error_count < 10)
        $display("text_color readback: expected %h, got %h", color_model, prdata[7:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    in_item_t   it;
    int         start;
    int         pick;
    int         line_len;
    logic [7:0] phase_colors [PHASES];
    for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;
    cursor_model = '0;
    color_model  = RESET_COLOR;
    phase_colors = '{8'h00, 8'hFF, 8'h00, 8'h1E, 8'h00};
    phase_colors[2] = 8'($urandom_range(0, 255));
    phase_colors[4] = 8'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_READ, 8'hFF, 8'hFF, 7'd79, 5'd24));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd80, 5'd0));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd25));
    submit(make_item(MODE_ERASE, 8'h00, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_PUT, 8'h41, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_PUT, 8'hFF, 8'hFF, 7'd127, 5'd31));
    submit(make_item(MODE_PUT, 8'h00, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd24));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd1, 5'd24));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd2, 5'd24));
    submit(make_item(MODE_ERASE, 8'hFF, 8'hFF, 7'd127, 5'd31));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd2, 5'd24));
    submit(make_item(MODE_PUT, NEWLINE_CHAR, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd23));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd24));
    submit(make_item(MODE_WRITE, 8'hFF, 8'hFF, 7'd0, 5'd0));
    submit(make_item(MODE_WRITE, 8'h00, 8'h00, 7'd79, 5'd24));
    submit(make_item(MODE_WRITE, 8'h55, 8'hAA, 7'd127, 5'd31));
    submit(make_item(MODE_WRITE, 8'h55, 8'hAA, 7'd80, 5'd0));
    submit(make_item(MODE_WRITE, 8'h55, 8'hAA, 7'd0, 5'd25));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    submit(make_item(MODE_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    wait_until_idle();

    program_color(UNMAPPED_ADDR, 32'h0000_00FF);
    for (int p = 0; p < PHASES; p++) begin
      program_color(TEXT_COLOR_ADDR, {24'h0, phase_colors[p]});
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          line_len = $urandom_range(1, 100);
          for (int k = 0; k < line_len; k++) begin
            it = random_item();
            if ($urandom_range(0, 15) == 0) begin
              it.mode = MODE_ERASE;
            end else begin
              it.mode = MODE_PUT;
              if (it.char_code == NEWLINE_CHAR) it.char_code = BLANK_CHAR;
            end
            submit(it);
          end
          if ($urandom_range(0, 9) < 6) begin
            it = random_item();
            it.mode = MODE_PUT;
            it.char_code = NEWLINE_CHAR;
            submit(it);
          end
        end else if (pick < 75) begin
          it = place(random_item());
          it.mode = MODE_WRITE;
          submit(it);
          it.mode = MODE_READ;
          submit(it);
        end else if (pick < 93) begin
          it = place(random_item());
          it.mode = MODE_READ;
          if ($urandom_range(0, 2) == 0) it.pos_row = ROW_W'(ROWS - 1);
          submit(it);
        end else begin
          submit(random_item());
        end
      end
      wait_until_idle();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_cell_writer_top.sv
design/tcw_checker.sv
dv/testbench.sv
